// ===== hdl/tqle_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tqle_pkg
// Shared types and constants for the tabular Q-learning engine.
// ----------------------------------------------------------------------------
package tqle_pkg;

    localparam int unsigned REGIME_W  = 2;
    localparam int unsigned VOL_W     = 16;
    localparam int unsigned SENT_W    = 16;
    localparam int unsigned ACT_W     = 3;
    localparam int unsigned Q_W       = 32;
    localparam int unsigned RATE_W    = 24;
    localparam int unsigned FRAC16_W  = 16;
    localparam int unsigned SUM_W     = 48;
    localparam int unsigned CNT_W     = 32;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [RATE_W-1:0] EXPLORE_RESET = 24'd5033165;
    localparam logic [FRAC16_W-1:0] LR_RESET    = 16'd6554;
    localparam logic [FRAC16_W-1:0] GAMMA_RESET = 16'd58982;
    localparam logic [RATE_W-1:0] FLOOR_RESET   = 24'd838861;
    localparam logic [RATE_W-1:0] DECAY_RESET   = 24'd16775538;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LR    = 2'd0,
        CFG_GAMMA = 2'd1,
        CFG_FLOOR = 2'd2,
        CFG_DECAY = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        CMD_CHOOSE = 1'b0,
        CMD_APPLY  = 1'b1
    } t_cmd;

    // Item as passed from the front end to the back end
    typedef struct packed {
        t_cmd                    cmd;
        logic [15:0]             row;
        logic [ACT_W-1:0]        taken_action;
        logic                    taken_ok;
        logic signed [Q_W-1:0]   reward;
        logic [RATE_W-1:0]       explore_draw;
        logic [ACT_W-1:0]        random_action;
    } t_item;

endpackage
`default_nettype wire

// ===== hdl/tqle_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tqle_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module tqle_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1500
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/tqle_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tqle_front
// Accepts items, buckets the situation into a table row and queues the item.
// ----------------------------------------------------------------------------
module tqle_front
    import tqle_pkg::*;
#(
    parameter int unsigned NUM_ACTIONS = 5,
    parameter int unsigned NUM_REGIMES = 3,
    parameter int unsigned NUM_BUCKETS = 10
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_start,
    output logic                   o_busy,
    input  wire                    i_command,
    input  wire [REGIME_W-1:0]     i_regime,
    input  wire [VOL_W-1:0]        i_volatility,
    input  wire signed [SENT_W-1:0] i_sentiment,
    input  wire [ACT_W-1:0]        i_taken_action,
    input  wire signed [Q_W-1:0]   i_reward,
    input  wire [RATE_W-1:0]       i_explore_draw,
    input  wire [ACT_W-1:0]        i_random_action,
    output logic                   o_q_valid,
    output t_item                  o_q_item,
    input  wire                    i_q_pop
);
    localparam int unsigned BW = $clog2(NUM_BUCKETS) + 1;
    localparam int unsigned DEPTH = 2;

    // two-entry queue
    t_item         r_buf [DEPTH];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          s_acc;
    t_item         s_item;

    logic [VOL_W+4:0]   s_vmul;
    logic [VOL_W+4:0]   s_vb;
    logic signed [SENT_W+1:0] s_sadd;
    logic [SENT_W+5:0]  s_smul;
    logic [SENT_W+5:0]  s_sb;
    logic [REGIME_W-1:0] s_reg;
    logic [ACT_W-1:0]   s_rand;

    always_comb begin
        s_vmul = 21'(i_volatility) * 21'(NUM_BUCKETS);
        s_vb   = s_vmul >> 12;
        if (s_vb > 21'(NUM_BUCKETS - 1)) s_vb = 21'(NUM_BUCKETS - 1);
        s_sadd = 18'(i_sentiment) + 18'sd16384;
        s_smul = s_sadd[17] ? '0 : 22'(s_sadd[16:0]) * 22'(NUM_BUCKETS);
        s_sb   = s_smul >> 15;
        if (s_sb > 22'(NUM_BUCKETS - 1)) s_sb = 22'(NUM_BUCKETS - 1);
        s_reg  = (32'(i_regime) > NUM_REGIMES - 1) ? REGIME_W'(NUM_REGIMES - 1) : i_regime;
        // reduce the 3-bit action into range by repeated subtraction
        s_rand = i_random_action;
        for (int k = 0; k < 4; k++) begin
            if (32'(s_rand) >= NUM_ACTIONS) s_rand = s_rand - ACT_W'(NUM_ACTIONS);
        end
        s_item.cmd           = t_cmd'(i_command);
        s_item.row           = 16'(32'(s_reg) * NUM_BUCKETS * NUM_BUCKETS
                               + 32'(s_vb[BW-1:0]) * NUM_BUCKETS + 32'(s_sb[BW-1:0]));
        s_item.taken_action  = i_taken_action;
        s_item.taken_ok      = 32'(i_taken_action) < NUM_ACTIONS;
        s_item.reward        = i_reward;
        s_item.explore_draw  = i_explore_draw;
        s_item.random_action = s_rand;
    end

    assign o_busy    = (r_cnt == 2'(DEPTH));
    assign s_acc     = i_start && !o_busy;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_buf[r_wp] <= s_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (s_acc) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(s_acc) - 2'(i_q_pop);
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> o_q_valid) else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(DEPTH)) else $error("queue overfull");
    a_full_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'(DEPTH)) && !i_q_pop |=> o_busy) else $error("busy lost");
endmodule
`default_nettype wire

// ===== hdl/tqle_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tqle_back
// Reads a table row, selects or updates an action value, keeps the counters.
// Clears the table after reset.
// ----------------------------------------------------------------------------
module tqle_back
    import tqle_pkg::*;
#(
    parameter int unsigned NUM_ACTIONS = 5,
    parameter int unsigned NUM_ROWS    = 300
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_q_valid,
    input  t_item                   i_q_item,
    output logic                    o_q_pop,
    input  wire [FRAC16_W-1:0]      i_lr,
    input  wire [FRAC16_W-1:0]      i_gamma,
    input  wire [RATE_W-1:0]        i_floor,
    input  wire [RATE_W-1:0]        i_decay,
    output logic                    o_done,
    output logic [ACT_W-1:0]        o_chosen_action,
    output logic                    o_explored,
    output logic signed [Q_W-1:0]   o_q_value,
    output logic signed [SUM_W-1:0] o_reward_total,
    output logic [CNT_W-1:0]        o_step_count
);
    localparam int unsigned DEPTH = NUM_ROWS * NUM_ACTIONS;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned AIW   = $clog2(NUM_ACTIONS + 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_SCAN, S_DECIDE, S_MUL1, S_MUL2, S_MUL3, S_WRITE
    } t_state;

    t_state r_state;
    t_item  r_item;
    logic [AW-1:0]   r_clr;
    logic [AIW-1:0]  r_ridx;
    logic [AIW-1:0]  r_scnt;
    logic [AW-1:0]   r_base;
    logic signed [Q_W-1:0] r_best_q, r_sel_q;
    logic [ACT_W-1:0] r_best;
    logic [RATE_W-1:0] r_rate;
    logic signed [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_cnt;
    logic signed [49:0] r_prod;
    logic signed [Q_W:0] r_target;
    logic signed [Q_W+1:0] r_err;

    logic           s_we;
    logic [AW-1:0]  s_waddr, s_raddr;
    logic [Q_W-1:0] s_wdata, s_rdata;
    logic [47:0]    s_rmul;
    logic [RATE_W-1:0] s_newrate;
    logic signed [Q_W+2:0] s_nq;
    logic signed [Q_W-1:0] s_nq_sat;
    logic signed [SUM_W:0] s_sum;

    tqle_ram #(.WIDTH(Q_W), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (s_we),
        .i_waddr(s_waddr),
        .i_wdata(s_wdata),
        .i_raddr(s_raddr),
        .o_rdata(s_rdata)
    );

    always_comb begin
        s_raddr = r_base + AW'(r_ridx);
        s_we    = 1'b0;
        s_waddr = r_clr;
        s_wdata = '0;
        s_rmul  = 48'(r_rate) * 48'(i_decay);
        s_newrate = (s_rmul[47:24] < i_floor) ? i_floor : s_rmul[47:24];
        s_nq    = 35'(r_sel_q) + 35'(r_prod >>> 16);
        s_nq_sat = (s_nq > 35'sd2147483647) ? 32'sh7FFFFFFF :
                   (s_nq < -35'sd2147483648) ? 32'sh80000000 : s_nq[Q_W-1:0];
        s_sum   = 49'(r_sum) + 49'(r_item.reward);
        if (r_state == S_CLEAR) begin
            s_we = 1'b1;
        end else if (r_state == S_WRITE && r_item.taken_ok) begin
            s_we    = 1'b1;
            s_waddr = r_base + AW'(r_item.taken_action);
            s_wdata = s_nq_sat;
        end
    end

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;

    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_rate  <= EXPLORE_RESET;
            r_sum   <= '0;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_item  <= i_q_item;
                        r_base  <= AW'(32'(i_q_item.row) * NUM_ACTIONS);
                        r_ridx  <= '0;
                        r_scnt  <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    // read address steps ahead; the registered read returns its data in the next cycle
                    r_ridx  <= r_ridx + 1'b1;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_ridx != AIW'(NUM_ACTIONS)) r_ridx <= r_ridx + 1'b1;
                    if (r_scnt == '0 || $signed(s_rdata) > r_best_q) begin
                        r_best_q <= s_rdata;
                        r_best   <= ACT_W'(r_scnt);
                    end
                    if ((r_item.cmd == CMD_CHOOSE && ACT_W'(r_scnt) == r_item.random_action)
                        || (r_item.cmd == CMD_APPLY && ACT_W'(r_scnt) == r_item.taken_action))
                        r_sel_q <= s_rdata;
                    r_scnt <= r_scnt + 1'b1;
                    if (r_scnt == AIW'(NUM_ACTIONS - 1)) r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (r_item.cmd == CMD_CHOOSE) begin
                        o_done <= 1'b1;
                        if (r_item.explore_draw < r_rate) begin
                            o_chosen_action <= r_item.random_action;
                            o_explored      <= 1'b1;
                            o_q_value       <= r_sel_q;
                        end else begin
                            o_chosen_action <= r_best;
                            o_explored      <= 1'b0;
                            o_q_value       <= r_best_q;
                            r_rate          <= s_newrate;
                        end
                        o_reward_total <= r_sum;
                        o_step_count   <= r_cnt;
                        r_state <= S_IDLE;
                    end else begin
                        r_prod  <= 50'($signed({1'b0, i_gamma})) * 50'(r_best_q);
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_target <= 33'(r_item.reward) + 33'(r_prod >>> 16);
                    r_state  <= S_MUL2;
                end
                S_MUL2: begin
                    r_err   <= 34'(r_target) - 34'(r_sel_q);
                    r_state <= S_MUL3;
                end
                S_MUL3: begin
                    r_prod  <= 50'($signed({1'b0, i_lr})) * 50'(r_err);
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    o_done          <= 1'b1;
                    o_chosen_action <= r_item.taken_action;
                    o_explored      <= 1'b0;
                    o_q_value       <= r_item.taken_ok ? s_nq_sat : '0;
                    if (s_sum > 49'sh07FFFFFFFFFFF) begin
                        r_sum <= 48'sh7FFFFFFFFFFF; o_reward_total <= 48'sh7FFFFFFFFFFF;
                    end else if (s_sum < -49'sh0800000000000) begin
                        r_sum <= 48'sh800000000000; o_reward_total <= 48'sh800000000000;
                    end else begin
                        r_sum <= s_sum[SUM_W-1:0]; o_reward_total <= s_sum[SUM_W-1:0];
                    end
                    r_cnt        <= r_cnt + 1'b1;
                    o_step_count <= r_cnt + 1'b1;
                    r_state      <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> r_state == S_READ) else $error("pop without read");
    a_no_done_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |=> !o_done) else $error("result during clear");
    a_rate_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_state) == S_DECIDE && $past(r_item.cmd) == CMD_APPLY |-> $stable(r_rate))
        else $error("rate moved on apply");
endmodule
`default_nettype wire

// ===== hdl/tabular_q_learning_engine_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tabular_q_learning_engine_top
// Tabular Q-learning engine with epsilon-greedy action choice.
//
// Items enter on i_start while o_busy is low; a two-beat queue separates the
// front end (row bucketing) from the back end (table access and arithmetic).
// Each item gives one result, shown on o_done for one cycle; the receiver
// cannot stall it.
// The back end finishes one item before it takes the next; its pace is set by
// the single read port of the table, read one action per cycle, and the
// two dependent multiplies of the update.
// Configuration writes go through i_cfg_valid/o_cfg_ready at any time and
// must only be issued while the block is idle.
// After reset the table, NUM_REGIMES*NUM_BUCKETS^2*NUM_ACTIONS entries (1500
// by default), is cleared one entry a cycle; items queue meanwhile.
// ----------------------------------------------------------------------------
module tabular_q_learning_engine_top
    import tqle_pkg::*;
#(
    parameter int unsigned NUM_ACTIONS = 5,
    parameter int unsigned NUM_REGIMES = 3,
    parameter int unsigned NUM_BUCKETS = 10
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_start,
    output logic                    o_busy,
    input  wire                     i_command,
    input  wire [REGIME_W-1:0]      i_regime,
    input  wire [VOL_W-1:0]         i_volatility,
    input  wire signed [SENT_W-1:0] i_sentiment,
    input  wire [ACT_W-1:0]         i_taken_action,
    input  wire signed [Q_W-1:0]    i_reward,
    input  wire [RATE_W-1:0]        i_explore_draw,
    input  wire [ACT_W-1:0]         i_random_action,
    input  wire                     i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire [CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [RATE_W-1:0]        i_cfg_data,
    output logic                    o_done,
    output logic [ACT_W-1:0]        o_chosen_action,
    output logic                    o_explored,
    output logic signed [Q_W-1:0]   o_q_value,
    output logic signed [SUM_W-1:0] o_reward_total,
    output logic [CNT_W-1:0]        o_step_count
);
    localparam int unsigned NUM_ROWS = NUM_REGIMES * NUM_BUCKETS * NUM_BUCKETS;

    logic [FRAC16_W-1:0] r_lr, r_gamma;
    logic [RATE_W-1:0]   r_floor, r_decay;
    logic  s_q_valid, s_q_pop;
    t_item s_q_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr    <= LR_RESET;
            r_gamma <= GAMMA_RESET;
            r_floor <= FLOOR_RESET;
            r_decay <= DECAY_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LR:    r_lr    <= i_cfg_data[FRAC16_W-1:0];
                CFG_GAMMA: r_gamma <= i_cfg_data[FRAC16_W-1:0];
                CFG_FLOOR: r_floor <= i_cfg_data;
                CFG_DECAY: r_decay <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tqle_front #(
        .NUM_ACTIONS(NUM_ACTIONS), .NUM_REGIMES(NUM_REGIMES), .NUM_BUCKETS(NUM_BUCKETS)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_command(i_command), .i_regime(i_regime), .i_volatility(i_volatility),
        .i_sentiment(i_sentiment), .i_taken_action(i_taken_action), .i_reward(i_reward),
        .i_explore_draw(i_explore_draw), .i_random_action(i_random_action),
        .o_q_valid(s_q_valid), .o_q_item(s_q_item), .i_q_pop(s_q_pop)
    );

    tqle_back #(.NUM_ACTIONS(NUM_ACTIONS), .NUM_ROWS(NUM_ROWS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(s_q_valid), .i_q_item(s_q_item),
        .o_q_pop(s_q_pop), .i_lr(r_lr), .i_gamma(r_gamma), .i_floor(r_floor),
        .i_decay(r_decay), .o_done(o_done), .o_chosen_action(o_chosen_action),
        .o_explored(o_explored), .o_q_value(o_q_value), .o_reward_total(o_reward_total),
        .o_step_count(o_step_count)
    );
endmodule
`default_nettype wire
